### rtl/calculator_to_seven_segment_digits_unit_macros.svh
// assertion macros for the calculator display unit
`ifndef CALCULATOR_TO_SEVEN_SEGMENT_DIGITS_UNIT_MACROS_SVH
`define CALCULATOR_TO_SEVEN_SEGMENT_DIGITS_UNIT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked also while reset is high
`define CSD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/csd_pkg.sv
package csd_pkg;
   localparam int OP_W = 2;
   localparam int DATA_W = 64;
   localparam int POS_W = 4;
   localparam int DIGIT_W = 4;
   localparam int SEG_W = 7;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_ADD = 2'd0;
   localparam logic [OP_W-1:0] OP_SUB = 2'd1;
   localparam logic [OP_W-1:0] OP_MUL = 2'd2;
   localparam logic [OP_W-1:0] OP_DIV = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK = 2'd0;
   localparam logic [STAT_W-1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [STAT_W-1:0] status;
   } result_type;

   function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0: s = 7'h3F;
         4'd1: s = 7'h06;
         4'd2: s = 7'h5B;
         4'd3: s = 7'h4F;
         4'd4: s = 7'h66;
         4'd5: s = 7'h6D;
         4'd6: s = 7'h7D;
         4'd7: s = 7'h07;
         4'd8: s = 7'h7F;
         default: s = 7'h6F;
      endcase
      return s;
   endfunction
endpackage

### rtl/csd_front.sv
// front: arithmetic unit; add/sub computed on accept, multiply by summing
// 32-bit partial products in turn, divide one quotient bit per cycle
module csd_front #(
   parameter int NUM_DIGITS = 11
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic [csd_pkg::OP_W-1:0] in_op,
   input  logic [csd_pkg::DATA_W-1:0] in_a,
   input  logic [csd_pkg::DATA_W-1:0] in_b,
   output logic out_valid,
   input  logic out_ready,
   output csd_pkg::result_type out_res
);
   import csd_pkg::*;

   localparam logic [DATA_W-1:0] LIMIT = DATA_W'(64'd10 ** NUM_DIGITS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] mstep_ff, mstep_in;
   logic [6:0] dcnt_ff, dcnt_in;
   logic [DATA_W-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in, rem_ff, rem_in;
   logic neg_ff, neg_in, dz_ff, dz_in;
   logic [31:0] pa, pb;
   logic [63:0] pp;
   logic [DATA_W:0] trial;
   logic [DATA_W-1:0] shrem, res;
   logic [STAT_W-1:0] st;

   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);

   always_comb begin
      res = acc_ff;
      if (neg_ff) res = DATA_W'(0) - acc_ff;
      if (dz_ff) res = '0;
      st = ST_OK;
      if (dz_ff) st = ST_DIV_ZERO;
      else if (res[DATA_W-1] || res >= LIMIT) st = ST_RANGE;
      out_res.value = res;
      out_res.status = st;
   end

   always_comb begin
      case (mstep_ff)
         3'd0: begin pa = a_ff[31:0]; pb = b_ff[31:0]; end
         3'd1: begin pa = a_ff[63:32]; pb = b_ff[31:0]; end
         default: begin pa = a_ff[31:0]; pb = b_ff[63:32]; end
      endcase
   end
   always_comb pp = pa * pb;

   always_comb begin
      shrem = {rem_ff[DATA_W-2:0], a_ff[DATA_W-1]};
      trial = {1'b0, shrem} - {1'b0, b_ff};
   end

   always_comb begin
      state_in = state_ff;
      mstep_in = mstep_ff;
      dcnt_in = dcnt_ff;
      a_in = a_ff; b_in = b_ff; acc_in = acc_ff; rem_in = rem_ff;
      neg_in = neg_ff; dz_in = dz_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               neg_in = 1'b0; dz_in = 1'b0;
               a_in = in_a; b_in = in_b;
               case (in_op)
                  OP_ADD: begin acc_in = in_a + in_b; state_in = S_DONE; end
                  OP_SUB: begin acc_in = in_a - in_b; state_in = S_DONE; end
                  OP_MUL: begin acc_in = '0; mstep_in = '0; state_in = S_MUL; end
                  default: begin
                     if (in_b == '0) begin
                        dz_in = 1'b1; acc_in = '0; state_in = S_DONE;
                     end else begin
                        a_in = in_a[DATA_W-1] ? DATA_W'(0) - in_a : in_a;
                        b_in = in_b[DATA_W-1] ? DATA_W'(0) - in_b : in_b;
                        neg_in = in_a[DATA_W-1] ^ in_b[DATA_W-1];
                        acc_in = '0; rem_in = '0; dcnt_in = '0;
                        state_in = S_DIV;
                     end
                  end
               endcase
            end
         end
         S_MUL: begin
            case (mstep_ff)
               3'd0: acc_in = acc_ff + pp;
               default: acc_in = acc_ff + {pp[31:0], 32'd0};
            endcase
            mstep_in = mstep_ff + 3'd1;
            if (mstep_ff == 3'd2) state_in = S_DONE;
         end
         S_DIV: begin
            a_in = {a_ff[DATA_W-2:0], 1'b0};
            if (!trial[DATA_W]) begin
               rem_in = trial[DATA_W-1:0];
               acc_in = {acc_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = shrem;
               acc_in = {acc_ff[DATA_W-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 7'd1;
            if (dcnt_ff == 7'(DATA_W - 1)) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mstep_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         mstep_ff <= mstep_in;
         dcnt_ff <= dcnt_in;
      end
      a_ff <= a_in; b_ff <= b_in; acc_ff <= acc_in; rem_ff <= rem_in;
      neg_ff <= neg_in; dz_ff <= dz_in;
   end
endmodule

### rtl/csd_queue.sv
// two-entry queue between the arithmetic front and the digit back end
module csd_queue (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  csd_pkg::result_type in_res,
   output logic out_valid,
   input  logic out_ready,
   output csd_pkg::result_type out_res
);
   import csd_pkg::*;

   result_type mem_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_res = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_res;
   end
endmodule

### rtl/csd_back.sv
// back end: finds one decimal digit per cycle unless the output stalls, by
// comparing with multiples of the current power of ten; output is registered
module csd_back #(
   parameter int NUM_DIGITS = 11
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  csd_pkg::result_type in_res,
   output logic out_valid,
   input  logic out_ready,
   output logic [csd_pkg::DATA_W-1:0] out_value,
   output logic [csd_pkg::POS_W-1:0] out_pos,
   output logic [csd_pkg::DIGIT_W-1:0] out_digit,
   output logic [csd_pkg::SEG_W-1:0] out_seg,
   output logic [csd_pkg::STAT_W-1:0] out_status,
   output logic out_last
);
   import csd_pkg::*;

   localparam int CNT_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_DIGITS - 1);

   logic busy_ff, busy_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [DATA_W-1:0] rem_ff, rem_in, val_ff, val_in;
   logic [STAT_W-1:0] st_ff, st_in;
   logic ov_ff, ov_in;
   logic [DATA_W-1:0] ovalue_ff, ovalue_in;
   logic [POS_W-1:0] opos_ff, opos_in;
   logic [DIGIT_W-1:0] odig_ff, odig_in;
   logic [SEG_W-1:0] oseg_ff, oseg_in;
   logic [STAT_W-1:0] ost_ff, ost_in;
   logic olast_ff, olast_in;
   logic [DATA_W-1:0] pw_tab [NUM_DIGITS];
   logic [DATA_W-1:0] pw;
   logic [DIGIT_W-1:0] d;
   logic [DATA_W-1:0] sub;
   logic [DATA_W+3:0] m;
   logic emit;
   logic last_emit;

   assign out_valid = ov_ff;
   assign out_value = ovalue_ff;
   assign out_pos = opos_ff;
   assign out_digit = odig_ff;
   assign out_seg = oseg_ff;
   assign out_status = ost_ff;
   assign out_last = olast_ff;
   assign emit = busy_ff && (!ov_ff || out_ready);
   assign last_emit = emit && (idx_ff == LAST_IDX);
   // next request loads on the edge that emits the units digit
   assign in_ready = !busy_ff || last_emit;

   // constant powers of ten, most significant position first
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         pw_tab[i] = 64'd10 ** (NUM_DIGITS - 1 - i);
      end
   end
   assign pw = pw_tab[idx_ff];

   // digit by compare against k*pw for k=1..9 (independent compares)
   always_comb begin
      d = '0;
      for (int k = 1; k <= 9; k++) begin
         m = (DATA_W+4)'(pw) * (DATA_W+4)'(k);
         if ({4'd0, rem_ff} >= m) d = DIGIT_W'(k);
      end
      sub = DATA_W'((DATA_W+4)'(pw) * (DATA_W+4)'(d));
   end

   always_comb begin
      busy_in = busy_ff; idx_in = idx_ff; rem_in = rem_ff;
      val_in = val_ff; st_in = st_ff;
      ov_in = ov_ff && !out_ready;
      ovalue_in = ovalue_ff; opos_in = opos_ff; odig_in = odig_ff;
      oseg_in = oseg_ff; ost_in = ost_ff; olast_in = olast_ff;
      if (emit) begin
         ov_in = 1'b1;
         ovalue_in = val_ff;
         opos_in = POS_W'(idx_ff);
         ost_in = st_ff;
         olast_in = (idx_ff == LAST_IDX);
         odig_in = (st_ff == ST_OK) ? d : '0;
         oseg_in = (st_ff == ST_OK) ? seg_decode(d) : '0;
         rem_in = rem_ff - sub;
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + CNT_W'(1);
         if (idx_ff == LAST_IDX) busy_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         busy_in = 1'b1; idx_in = '0; rem_in = in_res.value;
         val_in = in_res.value; st_in = in_res.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; ov_ff <= 1'b0; idx_ff <= '0;
      end else begin
         busy_ff <= busy_in; ov_ff <= ov_in; idx_ff <= idx_in;
      end
      rem_ff <= rem_in; val_ff <= val_in; st_ff <= st_in;
      ovalue_ff <= ovalue_in; opos_ff <= opos_in; odig_ff <= odig_in;
      oseg_ff <= oseg_in; ost_ff <= ost_in; olast_ff <= olast_in;
   end
endmodule

### rtl/calculator_to_seven_segment_digits_unit.sv
// front computes the result (divide one quotient bit a cycle) and takes a new
// request only when idle; the queue buffers results and the back end emits
// one digit per cycle unless stalled by rsp_tready, loading the next request
// as it emits the units digit
// reset: synchronous active high, clears front state, queue and output valid
module calculator_to_seven_segment_digits_unit #(
   parameter int NUM_DIGITS = 11
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // [1:0] req_type, [65:2] operand_a, [129:66] operand_b, [135:130] zero
   input  logic [135:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // [63:0] result_value, [67:64] digit_position, [71:68] digit_value,
   // [78:72] segments, [80:79] status
   output logic [87:0] rsp_tdata,
   output logic rsp_tlast
);
   import csd_pkg::*;

   // front to queue
   logic f_valid, f_ready;
   result_type f_res;
   // queue to back end
   logic q_valid, q_ready;
   result_type q_res;
   logic [DATA_W-1:0] r_value;
   logic [POS_W-1:0] r_pos;
   logic [DIGIT_W-1:0] r_digit;
   logic [SEG_W-1:0] r_seg;
   logic [STAT_W-1:0] r_status;

   csd_front #(.NUM_DIGITS(NUM_DIGITS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_op(req_tdata[1:0]), .in_a(req_tdata[65:2]), .in_b(req_tdata[129:66]),
      .out_valid(f_valid), .out_ready(f_ready), .out_res(f_res)
   );

   csd_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_res(f_res),
      .out_valid(q_valid), .out_ready(q_ready), .out_res(q_res)
   );

   csd_back #(.NUM_DIGITS(NUM_DIGITS)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_res(q_res),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_value(r_value), .out_pos(r_pos), .out_digit(r_digit),
      .out_seg(r_seg), .out_status(r_status), .out_last(rsp_tlast)
   );

   // pack result fields, zero fill to whole bytes
   assign rsp_tdata = {7'd0, r_status, r_seg, r_digit, r_pos, r_value};
endmodule

### rtl/csd_checker.sv
`include "calculator_to_seven_segment_digits_unit_macros.svh"
module csd_checker #(
   parameter int NUM_DIGITS = 11
) (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [87:0] rsp_tdata,
   input logic rsp_tlast
);
   `CSD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp dropped while stalled")
   `CSD_ASSERT(a_blank, clock, reset, rsp_tvalid && rsp_tdata[80:79] != 2'd0 |-> rsp_tdata[78:68] == 11'd0, "flagged digit not blank")
   `CSD_ASSERT(a_seg_ok, clock, reset, rsp_tvalid && rsp_tdata[80:79] == 2'd0 |-> rsp_tdata[78:72] != 7'd0, "ok digit without segments")
   `CSD_ASSERT(a_last_pos, clock, reset, rsp_tvalid && rsp_tlast |-> rsp_tdata[67:64] == 4'(NUM_DIGITS - 1), "tlast off the units digit")
   `CSD_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid, "rsp valid after reset")
endmodule

bind calculator_to_seven_segment_digits_unit csd_checker #(.NUM_DIGITS(NUM_DIGITS)) u_csd_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
